### hdl/assert_macros.svh
// Assertion macros shared by the grid keypoint suppression RTL.
// Used by the top level; expects a clock named clk and reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GKN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grid keypoint suppression check failed");

// Next-cycle implication, checked out of reset.
`define GKN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grid keypoint suppression check failed");

`endif

### hdl/gkn_pkg.sv
// Shared types and constants for the grid keypoint suppression block.
// No dependencies; imported by every module of the block but gkn_cell_mem.
package gkn_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int MAX_RADIUS     = 15;

  // field widths
  localparam int ACT_W  = 2;
  localparam int XPOS_W = 10;
  localparam int YPOS_W = 9;
  localparam int GW_W   = 11;
  localparam int GH_W   = 10;
  localparam int RAD_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  // wide enough for any size up to 4096 plus one
  localparam int SZ_W = 13;

  // clear generation tag stored with each cell
  localparam int EPOCH_W = 4;
  localparam int CELL_W  = 2;
  localparam int MEM_DW  = EPOCH_W + CELL_W;

  localparam logic [RAD_W-1:0] RAD_MAX = RAD_W'(MAX_RADIUS);

  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MARK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TEST  = 2'd2;

  localparam logic [CELL_W-1:0] CELL_EMPTY   = 2'd0;
  localparam logic [CELL_W-1:0] CELL_PENDING = 2'd1;
  localparam logic [CELL_W-1:0] CELL_KEPT    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 2'd2;

  localparam logic [GW_W-1:0]  GW_RESET  = 11'd640;
  localparam logic [GH_W-1:0]  GH_RESET  = 10'd480;
  localparam logic [RAD_W-1:0] RAD_RESET = 4'd4;

  // status from the sequencer to the top level
  typedef struct packed {
    logic busy;
    logic res_load;
    logic res_kept;
  } seq_status_t;

endpackage

### hdl/gkn_cell_mem.sv
// Single-port cell status memory: one address shared by the write and the read, registered read.
// Depends on nothing; widths come from parameters.
module gkn_cell_mem #(
  parameter int ADDR_W = 19,
  parameter int DATA_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

### hdl/gkn_seq.sv
// Sequencer and neighborhood walker: drives the cell memory one access per cycle.
// Depends on gkn_pkg.
module gkn_seq #(
  parameter int XW = 10,
  parameter int YW = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gkn_pkg::ACT_W-1:0]   act_in,
  input  logic [XW-1:0]               x_in,
  input  logic [YW-1:0]               y_in,
  input  logic [XW-1:0]               wm1,
  input  logic [YW-1:0]               hm1,
  input  logic [gkn_pkg::RAD_W-1:0]   rad,
  input  logic                        out_free,
  output gkn_pkg::seq_status_t        status,
  output logic                        mem_wr_en,
  output logic                        mem_rd_en,
  output logic [XW+YW-1:0]            mem_addr,
  output logic [gkn_pkg::MEM_DW-1:0]  mem_wr_data,
  input  logic [gkn_pkg::MEM_DW-1:0]  mem_rd_data
);
  import gkn_pkg::*;

  localparam int AW = XW + YW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_CENTRE = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;
  localparam logic [2:0] S_SWEEP  = 3'd6;

  localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

  logic [2:0]         state;
  logic [ACT_W-1:0]   act;
  logic [XW-1:0]      cx, x0, x1, wx;
  logic [YW-1:0]      cy, y0, y1, wy;
  logic [EPOCH_W-1:0] epoch;
  logic [AW-1:0]      sweep_cnt;
  logic               kept_r;

  logic [XW-1:0]      x0_next, x1_next;
  logic [YW-1:0]      y0_next, y1_next;
  logic [XW:0]        xs;
  logic [YW:0]        ys;
  logic [XW-1:0]      rx;
  logic [YW-1:0]      ry;
  logic [CELL_W-1:0]  rd_status;

  // neighborhood bounds, clipped to the grid in use
  always_comb begin
    rx = XW'(rad);
    ry = YW'(rad);
    x0_next = (cx >= rx) ? cx - rx : '0;
    y0_next = (cy >= ry) ? cy - ry : '0;
    xs = {1'b0, cx} + {1'b0, rx};
    ys = {1'b0, cy} + {1'b0, ry};
    x1_next = (xs > {1'b0, wm1}) ? wm1 : xs[XW-1:0];
    y1_next = (ys > {1'b0, hm1}) ? hm1 : ys[YW-1:0];
  end

  // a cell written before the last clear reads as empty
  assign rd_status = (mem_rd_data[MEM_DW-1:CELL_W] == epoch) ? mem_rd_data[CELL_W-1:0]
                                                               : CELL_EMPTY;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      epoch     <= '0;
      sweep_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (act_in == ACT_CLEAR) begin
              if (epoch == EPOCH_LAST) begin
                epoch     <= '0;
                sweep_cnt <= '0;
                state     <= S_SWEEP;
              end else begin
                epoch <= epoch + 1'b1;
              end
            end else if (act_in == ACT_MARK || act_in == ACT_TEST) begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: state <= S_DECIDE;
        S_DECIDE: begin
          if (act == ACT_MARK) begin
            state <= S_IDLE;
          end else if (rd_status == CELL_PENDING) begin
            state <= S_WALK;
          end else begin
            state <= S_OUT;
          end
        end
        S_WALK: begin
          if (wx == x1 && wy == y1) begin
            state <= S_CENTRE;
          end
        end
        S_CENTRE: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (&sweep_cnt) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      act <= act_in;
      cx  <= x_in;
      cy  <= y_in;
    end
    if (state == S_LOOK) begin
      x0 <= x0_next;
      x1 <= x1_next;
      y0 <= y0_next;
      y1 <= y1_next;
    end
    if (state == S_DECIDE) begin
      wx     <= x0;
      wy     <= y0;
      kept_r <= 1'b0;
    end
    if (state == S_WALK) begin
      // advance along the row, wrap to the next row
      if (wx == x1) begin
        wx <= x0;
        wy <= wy + 1'b1;
      end else begin
        wx <= wx + 1'b1;
      end
    end
    if (state == S_CENTRE) begin
      kept_r <= 1'b1;
    end
  end

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_rd_en   = 1'b0;
    mem_addr    = {cy, cx};
    mem_wr_data = {epoch, CELL_EMPTY};
    unique case (state)
      S_LOOK: mem_rd_en = 1'b1;
      S_DECIDE: begin
        mem_wr_en   = (act == ACT_MARK) && (rd_status == CELL_EMPTY);
        mem_wr_data = {epoch, CELL_PENDING};
      end
      S_WALK: begin
        mem_wr_en = 1'b1;
        mem_addr  = {wy, wx};
      end
      S_CENTRE: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {epoch, CELL_KEPT};
      end
      S_SWEEP: begin
        mem_wr_en   = 1'b1;
        mem_addr    = sweep_cnt;
        mem_wr_data = {{EPOCH_W{1'b0}}, CELL_EMPTY};
      end
      default: ;
    endcase
  end

  assign status.busy     = (state != S_IDLE);
  assign status.res_load = (state == S_OUT) && out_free;
  assign status.res_kept = kept_r;

endmodule

### hdl/grid_keypoint_nms.sv
// Grid keypoint suppression, top level: config registers, size clamping, result register.
// Depends on gkn_pkg, gkn_seq, gkn_cell_mem and assert_macros.svh.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+-----------
//  in      | in_valid, in_stall, action/x_pos/y_pos | into block
//  out     | out_valid, out_stall, kept             | out of block
//  cfg     | cfg_valid, cfg_ready, cfg_index/data   | into block
//
// Clear bumps the clear tag while idle. Mark reads the cell and writes it pending if empty.
// A test reads the cell; a kept one clears its clipped (2r+1)x(2r+1) square cell by cell,
// one memory access per cycle, and writes the centre kept; both kinds load the result.
// After reset, and on every 16th clear, a clearing pass writes all 2**(XW+YW) cells
// (524288 at the default sizes) while in_stall is high. A waiting result does not block
// the next item; the sequencer holds only when a new result is ready while the previous
// one is still stalled.
`include "assert_macros.svh"

module grid_keypoint_nms #(
  parameter int MAX_WIDTH  = gkn_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gkn_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [gkn_pkg::ACT_W-1:0]       action,
  input  logic [gkn_pkg::XPOS_W-1:0]      x_pos,
  input  logic [gkn_pkg::YPOS_W-1:0]      y_pos,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            kept,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gkn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gkn_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gkn_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;

  logic [GW_W-1:0]  grid_width;
  logic [GH_W-1:0]  grid_height;
  logic [RAD_W-1:0] suppress_radius;

  logic [SZ_W-1:0]  gw_ext, gh_ext, wm1_full, hm1_full, x_ext, y_ext;
  logic [XW-1:0]    wm1, x_sat;
  logic [YW-1:0]    hm1, y_sat;
  logic [RAD_W-1:0] rad;
  logic             out_free;

  seq_status_t      status;
  logic             mem_wr_en, mem_rd_en;
  logic [AW-1:0]    mem_addr;
  logic [MEM_DW-1:0] mem_wr_data, mem_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width      <= GW_RESET;
      grid_height     <= GH_RESET;
      suppress_radius <= RAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width      <= cfg_data;
        REG_GRID_HEIGHT: grid_height     <= cfg_data[GH_W-1:0];
        REG_RADIUS:      suppress_radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp sizes to [1, max] and saturate the coordinates
  always_comb begin
    gw_ext = SZ_W'(grid_width);
    gh_ext = SZ_W'(grid_height);
    priority if (gw_ext == '0)                  wm1_full = '0;
    else if (gw_ext > SZ_W'(MAX_WIDTH))         wm1_full = SZ_W'(MAX_WIDTH - 1);
    else                                        wm1_full = gw_ext - 1'b1;
    priority if (gh_ext == '0)                  hm1_full = '0;
    else if (gh_ext > SZ_W'(MAX_HEIGHT))        hm1_full = SZ_W'(MAX_HEIGHT - 1);
    else                                        hm1_full = gh_ext - 1'b1;
    wm1   = wm1_full[XW-1:0];
    hm1   = hm1_full[YW-1:0];
    x_ext = SZ_W'(x_pos);
    y_ext = SZ_W'(y_pos);
    x_sat = (x_ext > wm1_full) ? wm1 : x_ext[XW-1:0];
    y_sat = (y_ext > hm1_full) ? hm1 : y_ext[YW-1:0];
    rad   = (suppress_radius > RAD_MAX) ? RAD_MAX : suppress_radius;
  end

  assign in_stall = status.busy;
  assign out_free = !out_valid || !out_stall;

  gkn_seq #(
    .XW (XW),
    .YW (YW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (in_valid && !in_stall),
    .act_in      (action),
    .x_in        (x_sat),
    .y_in        (y_sat),
    .wm1         (wm1),
    .hm1         (hm1),
    .rad         (rad),
    .out_free    (out_free),
    .status      (status),
    .mem_wr_en   (mem_wr_en),
    .mem_rd_en   (mem_rd_en),
    .mem_addr    (mem_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_data (mem_rd_data)
  );

  gkn_cell_mem #(
    .ADDR_W (AW),
    .DATA_W (MEM_DW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .rd_en   (mem_rd_en),
    .addr    (mem_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  // result register parts the sequencer from the output channel
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.res_load) begin
      kept <= status.res_kept;
    end
  end

  `GKN_ASSERT_NOW(a_no_write_idle, !status.busy, !mem_wr_en)
  `GKN_ASSERT_NOW(a_load_when_free, status.res_load, !out_valid || !out_stall)
  `GKN_ASSERT_NEXT(a_mark_busy, in_valid && !in_stall && action == ACT_MARK, in_stall)
  `GKN_ASSERT_NOW(a_single_access, mem_wr_en, !mem_rd_en)

endmodule

### bench/grid_keypoint_nms_checker.sv
// Checker for grid_keypoint_nms: watches the item, result and register channels and keeps
// its own copy of the occupancy grid to predict each test result, compared in order.
// Depends on gkn_pkg.
module grid_keypoint_nms_checker
  import gkn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [ACT_W-1:0]      action,
  input  logic [XPOS_W-1:0]     x_pos,
  input  logic [YPOS_W-1:0]     y_pos,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  kept,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_count,
  output int                    items_taken,
  output int                    results_taken,
  output int                    kept_count
);

  localparam int MAX_PRINTED = 50;

  logic [GW_W-1:0]   grid_width_q;
  logic [GH_W-1:0]   grid_height_q;
  logic [RAD_W-1:0]  radius_q;
  // cells missing from the map are empty
  logic [CELL_W-1:0] cell_state [int];
  bit                kept_expected [$];
  bit                expected_kept;

  task automatic report_mismatch(string msg);
    fail_count++;
    // keep the log short on a badly broken build
    if (fail_count <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Apply one item to the grid copy; queue the kept flag for a test.
  function automatic void predict_item(logic [ACT_W-1:0] act, logic [XPOS_W-1:0] xp,
                                       logic [YPOS_W-1:0] yp);
    int w, h, r, x, y, x0, x1, y0, y1, centre, i, j;
    logic [CELL_W-1:0] status;
    w = (grid_width_q == 0) ? 1 :
        ((grid_width_q > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(grid_width_q));
    h = (grid_height_q == 0) ? 1 :
        ((grid_height_q > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(grid_height_q));
    r = (radius_q > MAX_RADIUS) ? MAX_RADIUS : int'(radius_q);
    x = (int'(xp) > w - 1) ? w - 1 : int'(xp);
    y = (int'(yp) > h - 1) ? h - 1 : int'(yp);
    centre = y * MAX_WIDTH_DEF + x;
    status = cell_state.exists(centre) ? cell_state[centre] : CELL_EMPTY;
    case (act)
      ACT_CLEAR: cell_state.delete();
      ACT_MARK: begin
        if (status == CELL_EMPTY) cell_state[centre] = CELL_PENDING;
      end
      ACT_TEST: begin
        if (status != CELL_PENDING) begin
          kept_expected = {kept_expected, 1'b0};
        end else begin
          // clip the square to the grid in use, empty it, then keep the centre
          x0 = (x >= r) ? x - r : 0;
          y0 = (y >= r) ? y - r : 0;
          x1 = (x + r > w - 1) ? w - 1 : x + r;
          y1 = (y + r > h - 1) ? h - 1 : y + r;
          for (j = y0; j <= y1; j++)
            for (i = x0; i <= x1; i++)
              cell_state.delete(j * MAX_WIDTH_DEF + i);
          cell_state[centre] = CELL_KEPT;
          kept_expected = {kept_expected, 1'b1};
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      grid_width_q  = GW_RESET;
      grid_height_q = GH_RESET;
      radius_q      = RAD_RESET;
      cell_state.delete();
      kept_expected.delete();
      fail_count    = 0;
      items_taken   = 0;
      results_taken = 0;
      kept_count    = 0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        results_taken++;
        if (kept_expected.size() == 0) begin
          report_mismatch($sformatf("result kept=%0b with nothing expected", kept));
        end else begin
          expected_kept = kept_expected.pop_front();
          if (kept !== expected_kept)
            report_mismatch($sformatf("kept=%0b, expected %0b (result %0d)",
                                      kept, expected_kept, results_taken));
          else if (expected_kept)
            kept_count++;
        end
      end
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          REG_GRID_WIDTH:  grid_width_q  = cfg_data[GW_W-1:0];
          REG_GRID_HEIGHT: grid_height_q = cfg_data[GH_W-1:0];
          REG_RADIUS:      radius_q      = cfg_data[RAD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        items_taken++;
        predict_item(action, x_pos, y_pos);
      end
    end
    pending_count = kept_expected.size();
  end

endmodule

### bench/grid_keypoint_nms_tb.sv
// Testbench top for grid_keypoint_nms: clock, reset, register writes, item stimulus
// and result stalls; the verdict comes from grid_keypoint_nms_checker.
// Depends on gkn_pkg, grid_keypoint_nms and grid_keypoint_nms_checker.
module grid_keypoint_nms_tb;
  import gkn_pkg::*;

  // limit sized for the slowest correct run: reset clear pass plus every item a
  // full-radius kept walk behind long stalls
  localparam int CYCLE_LIMIT    = 8_000_000;
  // longest walk: a kept test at the largest radius
  localparam int DRAIN_CYCLES   = 1000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 122;
  localparam int MAX_GAP        = 60;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ACT_W-1:0]      action = ACT_CLEAR;
  logic [XPOS_W-1:0]     x_pos = '0;
  logic [YPOS_W-1:0]     y_pos = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  kept;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_GRID_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count, pending_count, items_taken, results_taken, kept_count;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cur_w = 640;
  int cur_h = 480;
  int cur_r = 4;
  int clears_left = 12;
  int settings_count = 0;
  int unsigned cycle_count = 0;

  grid_keypoint_nms u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .x_pos     (x_pos),
    .y_pos     (y_pos),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kept      (kept),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  grid_keypoint_nms_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .x_pos         (x_pos),
    .y_pos         (y_pos),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kept          (kept),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .items_taken   (items_taken),
    .results_taken (results_taken),
    .kept_count    (kept_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
      $display("grid_keypoint_nms_tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
  endtask

  // Write all three registers; bits above each register's width are random.
  task automatic program_grid(int w_raw, int h_raw, int r_raw);
    logic [CFG_DATA_W-1:0] data;
    data = w_raw[GW_W-1:0];
    write_reg(REG_GRID_WIDTH, data);
    data = CFG_DATA_W'($urandom);
    data[GH_W-1:0] = h_raw[GH_W-1:0];
    write_reg(REG_GRID_HEIGHT, data);
    data = CFG_DATA_W'($urandom);
    data[RAD_W-1:0] = r_raw[RAD_W-1:0];
    write_reg(REG_RADIUS, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_w = (w_raw == 0) ? 1 : ((w_raw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w_raw);
    cur_h = (h_raw == 0) ? 1 : ((h_raw > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h_raw);
    cur_r = r_raw;
    settings_count++;
  endtask

  // Leaves in_valid high after the item is taken; a drain, or a gap before the next item, lowers it.
  task automatic send_item(logic [ACT_W-1:0] act, int x, int y);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    x_pos    <= x[XPOS_W-1:0];
    y_pos    <= y[YPOS_W-1:0];
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Drop valid, wait for every expected result, then idle for the length of the longest walk.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Near the cluster centre, now and then anywhere in the field's range.
  function automatic int pick_coord(int centre, int spread, int bits);
    int v;
    if ($urandom_range(7) == 0) return $urandom_range((1 << bits) - 1);
    v = int'($urandom_range(2 * spread));
    v = v + centre - spread;
    return (v < 0) ? 0 : v;
  endfunction

  // Mostly mark-then-test bursts of clustered candidates, the rest single noise items.
  task automatic run_phase(int count);
    int sent, k, n, cx, cy, spread;
    logic [ACT_W-1:0] act;
    int xs[$];
    int ys[$];
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 75) begin
        if (clears_left > 0 && $urandom_range(9) == 0) begin
          send_item(ACT_CLEAR, $urandom, $urandom);
          clears_left--;
          sent++;
        end
        k = $urandom_range(12, 1);
        cx = $urandom_range(cur_w - 1);
        cy = $urandom_range(cur_h - 1);
        spread = cur_r + 3;
        xs.delete();
        ys.delete();
        for (n = 0; n < k; n++) begin
          xs = {xs, pick_coord(cx, spread, XPOS_W)};
          ys = {ys, pick_coord(cy, spread, YPOS_W)};
          send_item(ACT_MARK, xs[n], ys[n]);
        end
        // tests come in score order, which is mark order
        for (n = 0; n < k; n++) send_item(ACT_TEST, xs[n], ys[n]);
        sent += 2 * k;
      end else begin
        act = ACT_W'($urandom_range(3));
        if (act == ACT_CLEAR) begin
          if (clears_left > 0) clears_left--;
          else act = ACT_TEST;
        end
        if ($urandom_range(1) == 1)
          send_item(act, $urandom_range(cur_w - 1), $urandom_range(cur_h - 1));
        else
          send_item(act, $urandom, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    int p;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // small grid: edges, saturation, repeats, kept cells inside a neighbourhood
    program_grid(16, 16, 2);
    send_item(ACT_CLEAR, 0, 0);
    send_item(ACT_MARK, 0, 0);
    send_item(ACT_MARK, 15, 15);
    send_item(ACT_MARK, 5, 5);
    send_item(ACT_MARK, 5, 5);
    send_item(ACT_TEST, 5, 5);
    send_item(ACT_TEST, 5, 5);
    send_item(ACT_MARK, 5, 5);
    send_item(ACT_TEST, 8, 8);
    send_item(ACT_TEST, 1023, 511);
    send_item(ACT_TEST, 0, 0);
    send_item(ACT_W'(3), 1023, 511);
    send_item(ACT_MARK, 6, 6);
    send_item(ACT_TEST, 6, 6);
    send_item(ACT_MARK, 5, 5);
    send_item(ACT_TEST, 5, 5);
    drain();

    // zero sizes act as one cell, largest radius
    program_grid(0, 0, 15);
    send_item(ACT_MARK, 1023, 511);
    send_item(ACT_TEST, 0, 0);
    send_item(ACT_TEST, 0, 0);
    drain();

    // oversize registers saturate to the full grid, radius zero
    program_grid(2047, 1023, 0);
    send_item(ACT_MARK, 1023, 511);
    send_item(ACT_MARK, 1022, 511);
    send_item(ACT_TEST, 1023, 511);
    send_item(ACT_TEST, 1022, 511);
    send_item(ACT_TEST, 1023, 0);
    drain();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: program_grid($urandom_range(64, 8), $urandom_range(64, 8), $urandom_range(15));
        1: program_grid(2047, 1023, 15);
        2: program_grid(1, $urandom_range(8, 1), $urandom_range(15));
        3: program_grid($urandom_range(1024, 1), $urandom_range(512, 1), $urandom_range(15));
        4: program_grid(0, 0, 0);
        5: program_grid($urandom_range(128, 16), $urandom_range(16, 1), $urandom_range(3));
        6: program_grid(1024, 512, $urandom_range(15));
        default: program_grid($urandom_range(2047), $urandom_range(1023), $urandom_range(15));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 84; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 84; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      run_phase(PHASE_ITEMS);
      drain();
    end

    $display("covered %0d items and %0d results (%0d kept) over %0d grid settings,",
             items_taken, results_taken, kept_count, settings_count);
    $display("with sender gaps and result stalls off, heavy and light");
    if (fail_count == 0) begin
      $display("grid_keypoint_nms_tb OK");
    end else begin
      $display("grid_keypoint_nms_tb NOT OK");
    end
    $finish;
  end

endmodule
